[sv/assert_macros.svh]
// assertion macros for the dispatcher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

[sv/crrd_pkg.sv]
package crrd_pkg;
  localparam int MaxWorkers = 16;
  localparam int PosW = $clog2(MaxWorkers);
  localparam int CntW = $clog2(MaxWorkers + 1);

  localparam logic [1:0] OP_REG = 2'd0;
  localparam logic [1:0] OP_DEREG = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // command from controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic commit;   // apply table update and build result
  } crrd_cmd_t;
endpackage

[sv/crrd_datapath.sv]
// table of worker cells with a search on capture and a shift-to-back on commit
module crrd_datapath import crrd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  crrd_cmd_t        cmd,
  input  logic [1:0]       in_op,
  input  logic [15:0]      in_id,
  input  logic [7:0]       in_slots,
  output logic [1:0]       res_status,
  output logic [15:0]      res_id,
  output logic [6:0]       res_credit,
  output logic [CntW-1:0]  res_count
);
  logic [15:0]     ids [MaxWorkers];
  logic [6:0]      credits [MaxWorkers];
  logic [CntW-1:0] total;

  logic [1:0]      op;
  logic [15:0]     id;
  logic [6:0]      credit;
  logic            hit;
  logic [PosW-1:0] hit_pos;

  logic [MaxWorkers-1:0] id_match;
  logic [MaxWorkers-1:0] has_credit;
  logic            m_found, c_found;
  logic [PosW-1:0] m_pos, c_pos;

  // parallel compare over cells, first match by priority
  always_comb begin
    m_found = 1'b0;
    c_found = 1'b0;
    m_pos = '0;
    c_pos = '0;
    for (int i = 0; i < MaxWorkers; i++) begin
      id_match[i] = (CntW'(i) < total) && (ids[i] == in_id);
      has_credit[i] = (CntW'(i) < total) && (credits[i] != 7'd0);
    end
    for (int i = MaxWorkers - 1; i >= 0; i--) begin
      if (id_match[i]) begin
        m_found = 1'b1;
        m_pos = PosW'(i);
      end
      if (has_credit[i]) begin
        c_found = 1'b1;
        c_pos = PosW'(i);
      end
    end
  end

  // capture item and search result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      id <= in_id;
      credit <= in_slots[7] ? 7'd0 : in_slots[6:0];
      hit <= (in_op == OP_DISP) ? c_found : m_found;
      hit_pos <= (in_op == OP_DISP) ? c_pos : m_pos;
    end
  end

  logic            do_remove, do_append;
  logic [15:0]     app_id;
  logic [6:0]      app_credit;
  logic [CntW-1:0] total_next;
  logic [1:0]      status;
  logic [CntW-1:0] tail;

  // decide the update
  always_comb begin
    do_remove = 1'b0;
    do_append = 1'b0;
    app_id = id;
    app_credit = credit;
    status = ST_OK;
    case (op)
      OP_REG: begin
        if (hit) begin
          do_remove = 1'b1;
          do_append = 1'b1;
        end else if (total == CntW'(MaxWorkers)) begin
          status = ST_FULL;
        end else begin
          do_append = 1'b1;
        end
      end
      OP_DEREG: begin
        if (hit) do_remove = 1'b1;
        else status = ST_NOT_FOUND;
      end
      OP_DISP: begin
        if (hit) begin
          do_remove = 1'b1;
          do_append = 1'b1;
          app_id = ids[hit_pos];
          app_credit = credits[hit_pos] - 7'd1;
        end else begin
          status = ST_BUSY;
        end
      end
      default: ;
    endcase
    total_next = total - CntW'(do_remove) + CntW'(do_append);
    tail = total_next - 1'b1;
  end

  // shift cells above the removed one down by one, write appended at the tail
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < MaxWorkers; i++) begin
        if (do_append && CntW'(i) == tail) begin
          ids[i] <= app_id;
          credits[i] <= app_credit;
        end else if (do_remove && PosW'(i) >= hit_pos && i < MaxWorkers - 1) begin
          ids[i] <= ids[(i + 1) % MaxWorkers];
          credits[i] <= credits[(i + 1) % MaxWorkers];
        end
      end
      res_status <= status;
      res_id <= (op == OP_DISP && hit) ? app_id : 16'd0;
      res_credit <= (op == OP_DISP && hit) ? app_credit : 7'd0;
      res_count <= total_next;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) total <= '0;
    else if (cmd.commit) total <= total_next;
  end
endmodule

[sv/crrd_ctrl.sv]
// handshake sequencer: accept, commit, hold result
module crrd_ctrl import crrd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output crrd_cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0] state, state_next;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.load = in_valid && in_ready;
  assign cmd.commit = (state == S_EXEC);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

[sv/credit_round_robin_dispatcher.sv]
// Credit round-robin dispatcher: one request per transaction (register,
// deregister, dispatch), one result transaction each. In the accepting cycle
// the id or credit is compared against every table cell in parallel, and the
// search result is registered with the item. The next cycle shifts the table,
// appends at the back and loads the result register. The result is then
// offered and held until taken. The next item is accepted in the cycle after
// the result leaves, so one item is handled at a time and a waiting result
// holds off the next request. No clearing pass follows reset.
`include "assert_macros.svh"
module credit_round_robin_dispatcher import crrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // opcode[1:0], worker_id[17:2], slot_count[25:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status[1:0], chosen_id[17:2], credit_left[24:18],
                                     // worker_count[29:25]
);
  crrd_cmd_t       cmd;
  logic [1:0]      res_status;
  logic [15:0]     res_id;
  logic [6:0]      res_credit;
  logic [CntW-1:0] res_count;

  crrd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd)
  );

  crrd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .in_op(s_axis_tdata[1:0]), .in_id(s_axis_tdata[17:2]),
    .in_slots(s_axis_tdata[25:18]),
    .res_status(res_status), .res_id(res_id),
    .res_credit(res_credit), .res_count(res_count)
  );

  assign m_axis_tdata = {2'b00, 5'(res_count), res_credit, res_id, res_status};

  `ASSERT_CLK(a_no_overlap, clk, rst, !(s_axis_tready && m_axis_tvalid))
  `ASSERT_CLK(a_load_then_out, clk, rst, (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
  `ASSERT_CLK(a_count_range, clk, rst, m_axis_tvalid |-> (res_count <= CntW'(MaxWorkers)))
endmodule

[test/credit_round_robin_dispatcher_tb.sv]
`timescale 1ns / 1ps
module credit_round_robin_dispatcher_tb;
  import crrd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IdleLimit = 5000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] chosen_id;
    logic [6:0]  credit_left;
    logic [4:0]  worker_count;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // opcode, worker_id, slot_count
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;  // status, chosen_id, credit_left, worker_count

  // predictor copy of the worker table
  logic [15:0] tbl_ids[MaxWorkers];
  logic [6:0]  tbl_credits[MaxWorkers];
  int          tbl_total;
  outcome_t    pending_outcomes[$];
  int          fail_count;
  int          idle_cycles;
  bit          hold_off;
  logic [15:0] id_pool[8];

  credit_round_robin_dispatcher dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int find_worker(logic [15:0] id);
    for (int i = 0; i < tbl_total; i++)
      if (tbl_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_worker(int pos);
    for (int i = pos; i < tbl_total - 1; i++) begin
      tbl_ids[i] = tbl_ids[i + 1];
      tbl_credits[i] = tbl_credits[i + 1];
    end
    tbl_total--;
  endfunction

  function automatic void push_back_worker(logic [15:0] id, logic [6:0] credit);
    tbl_ids[tbl_total] = id;
    tbl_credits[tbl_total] = credit;
    tbl_total++;
  endfunction

  // next table state and the outcome of one request
  function automatic outcome_t predict_dispatch(logic [1:0] op, logic [15:0] id,
                                                logic signed [7:0] slots);
    outcome_t   o;
    int         pos;
    logic [6:0] credit;
    logic [15:0] wid;
    o = '0;
    o.status = ST_OK;
    credit = slots[7] ? 7'd0 : slots[6:0];
    pos = -1;
    case (op)
      OP_REG: begin
        pos = find_worker(id);
        if (pos >= 0) begin
          drop_worker(pos);
          push_back_worker(id, credit);
        end else if (tbl_total >= MaxWorkers) begin
          o.status = ST_FULL;
        end else begin
          push_back_worker(id, credit);
        end
      end
      OP_DEREG: begin
        pos = find_worker(id);
        if (pos >= 0) drop_worker(pos);
        else o.status = ST_NOT_FOUND;
      end
      OP_DISP: begin
        for (int i = 0; i < tbl_total; i++)
          if (tbl_credits[i] != 0 && pos < 0) pos = i;
        if (pos >= 0) begin
          wid = tbl_ids[pos];
          credit = tbl_credits[pos] - 7'd1;
          drop_worker(pos);
          push_back_worker(wid, credit);
          o.chosen_id = wid;
          o.credit_left = credit;
        end else begin
          o.status = ST_BUSY;
        end
      end
      default: ;
    endcase
    o.worker_count = tbl_total[4:0];
    return o;
  endfunction

  // offer one request after a random gap; valid stays high into a request with no gap
  task automatic send_request(logic [1:0] op, logic [15:0] id, logic [7:0] slots,
                              bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) s_axis_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, slots, id, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_outcomes.push_back(predict_dispatch(op, id, slots));
  endtask

  // receiver: random stalls per result, or a long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else if (m_axis_tvalid && m_axis_tready) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 6) == 0) || ($urandom_range(0, 3) == 0);
  end

  // compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[17:2], m_axis_tdata[24:18],
             m_axis_tdata[29:25]};
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); fail_count++;
        end
        if (got.chosen_id !== want.chosen_id) begin
          $error("chosen_id exp %0d got %0d", want.chosen_id, got.chosen_id); fail_count++;
        end
        if (got.credit_left !== want.credit_left) begin
          $error("credit_left exp %0d got %0d", want.credit_left, got.credit_left);
          fail_count++;
        end
        if (got.worker_count !== want.worker_count) begin
          $error("worker_count exp %0d got %0d", want.worker_count, got.worker_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OP_DISP, 16'h0, 8'h00);      // empty table
    send_request(OP_DEREG, 16'hFFFF, 8'h00);  // unknown id
    send_request(OP_REG, 16'h0000, 8'h7F);
    send_request(OP_REG, 16'hFFFF, 8'h80);    // negative clamps
    send_request(OP_REG, 16'h1234, 8'h01);
    send_request(OP_DISP, 16'hFFFF, 8'hFF);
    send_request(OP_DISP, 16'h0, 8'h00);
    send_request(OP_REG, 16'h0000, 8'hFF);    // existing, clamps, moves back
    send_request(OP_DISP, 16'h0, 8'h00);      // all busy
    send_request(OP_UNUSED, 16'hABCD, 8'h55);
    send_request(OP_DEREG, 16'h1234, 8'h00);
    send_request(OP_REG, 16'h0000, 8'h02);
    send_request(OP_DISP, 16'h0, 8'h00);
    send_request(OP_DISP, 16'h0, 8'h00);
  endtask

  // fill the table, overflow it, drain it
  task automatic test_full_table();
    for (int i = 0; i < MaxWorkers + 2; i++)
      send_request(OP_REG, 16'h0100 + i[15:0], 8'($urandom_range(0, 3)));
    for (int i = 0; i < MaxWorkers + 1; i++)
      send_request(OP_DEREG, 16'h0100 + i[15:0], 8'h00);
  endtask

  // receiver held off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) send_request(OP_REG, id_pool[i], 8'd5, 1);
    join
  endtask

  task automatic test_random(int count);
    logic [1:0]  op;
    logic [15:0] id;
    int          r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      op = r < 35 ? OP_REG : r < 55 ? OP_DEREG : r < 97 ? OP_DISP : OP_UNUSED;
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
      if (n % 300 < 40 && op == OP_REG) id = 16'($urandom);  // stretches that fill up
      send_request(op, id, 8'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 4)));
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    fail_count = 0;
    idle_cycles = 0;
    hold_off = 0;
    tbl_total = 0;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(880);
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
